FILE: design/jhs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Jacobi heat stencil package
// Shared constants and the configuration register map of the stencil sweep.
// ----------------------------------------------------------------------------
package jhs_pkg;

   // Default sizes of the line memories and of the heat values.
   localparam int MAX_COLUMNS_DEFAULT = 1024;
   localparam int MAX_ROWS_DEFAULT    = 1024;
   localparam int HEAT_WIDTH_DEFAULT  = 24;

   // Configuration port geometry and grid size limits.
   localparam int CFG_W           = 11;
   localparam int CSR_INDEX_W     = 1;
   localparam int GRID_SIZE_RESET = 1024;
   localparam int GRID_SIZE_MIN   = 3;

   // Configuration register map.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_GRID_COLUMNS = 1'b0,
      REG_GRID_ROWS    = 1'b1
   } csr_reg_type;

endpackage : jhs_pkg
`default_nettype wire

FILE: design/jacobi_heat_stencil_sweep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Jacobi heat stencil sweep
// One four-neighbor Jacobi relaxation sweep over a heat grid that streams in
// raster order, with a running maximum of the absolute change.
// ----------------------------------------------------------------------------
// Usage:
//   Grid cells enter on the req_ stream, one beat per cell in raster order;
//   req_tuser marks the first cell of a sweep. Each interior cell of the
//   previous row leaves on the rsp_ stream with its row, column, new heat and
//   the running maximum of |new - old|; rsp_tlast marks the last interior
//   cell. Border cells produce no beat.
//   The grid size is set through csr_ (index 0 columns, index 1 rows) while
//   the block is idle. Values below 3 or above the memory size are clamped.
//   An accepted cell passes stage 1, stage 2 and the output register in turn.
//   Throughput: one cell per cycle while the receiver keeps up, set by the single
//   write port of each line memory, which takes one row entry per cycle.
//   When the receiver stalls, the pipeline fills (three items) and then
//   req_tready drops until the output beat is taken.
//   Reset is synchronous: the position returns to the top left corner, the
//   residual clears and the grid size returns to 1024 by 1024. Line memory
//   contents are not cleared.
// ----------------------------------------------------------------------------
module jacobi_heat_stencil_sweep
   import jhs_pkg::*;
#(
   parameter  int MAX_COLUMNS = MAX_COLUMNS_DEFAULT,
   parameter  int MAX_ROWS    = MAX_ROWS_DEFAULT,
   parameter  int HEAT_WIDTH  = HEAT_WIDTH_DEFAULT,
   localparam int COL_W       = $clog2(MAX_COLUMNS),
   localparam int ROW_W       = $clog2(MAX_ROWS),
   localparam int REQ_W       = ((HEAT_WIDTH + 7) / 8) * 8,
   localparam int RSP_W       = ((ROW_W + COL_W + 2 * HEAT_WIDTH + 7) / 8) * 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Cell input.
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_W-1:0]       req_tdata,   // cell_heat
   input  wire logic                   req_tuser,   // frame_start
   // Result output.
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_W-1:0]       rsp_tdata,   // out_row, out_column,
                                                    // new_heat, residual_max
   output logic                        rsp_tlast,   // sweep_done
   // Configuration writes.
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]       csr_wdata
);

   localparam int COLS_W = COL_W + 1;
   localparam int ROWS_W = ROW_W + 1;
   localparam int CLW_A  = (CFG_W > COLS_W) ? CFG_W : COLS_W;
   localparam int CLW    = (CLW_A > ROWS_W) ? CLW_A : ROWS_W;
   localparam int SUM_W  = HEAT_WIDTH + 2;
   localparam int COLS_RESET_I =
      (GRID_SIZE_RESET > MAX_COLUMNS) ? MAX_COLUMNS : GRID_SIZE_RESET;
   localparam int ROWS_RESET_I =
      (GRID_SIZE_RESET > MAX_ROWS) ? MAX_ROWS : GRID_SIZE_RESET;
   localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(COLS_RESET_I);
   localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(ROWS_RESET_I);

   // ------------------------------------------------------------------------
   // Configuration: grid size, stored already clamped.
   // ------------------------------------------------------------------------
   logic [COLS_W-1:0] cols_ff;
   logic [COLS_W-1:0] cols_in;
   logic [ROWS_W-1:0] rows_ff;
   logic [ROWS_W-1:0] rows_in;
   logic [CLW-1:0]    cfg_val;
   logic [COLS_W-1:0] cols_clamp;
   logic [ROWS_W-1:0] rows_clamp;

   assign cfg_val = CLW'(csr_wdata);

   // Clamp the written size into the supported range.
   always_comb begin
      if (cfg_val < CLW'(GRID_SIZE_MIN)) begin
         cols_clamp = COLS_W'(GRID_SIZE_MIN);
      end else if (cfg_val > CLW'(MAX_COLUMNS)) begin
         cols_clamp = COLS_W'(MAX_COLUMNS);
      end else begin
         cols_clamp = COLS_W'(cfg_val);
      end
      if (cfg_val < CLW'(GRID_SIZE_MIN)) begin
         rows_clamp = ROWS_W'(GRID_SIZE_MIN);
      end else if (cfg_val > CLW'(MAX_ROWS)) begin
         rows_clamp = ROWS_W'(MAX_ROWS);
      end else begin
         rows_clamp = ROWS_W'(cfg_val);
      end
   end

   // Register write decode.
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            REG_GRID_COLUMNS: cols_in = cols_clamp;
            REG_GRID_ROWS:    rows_in = rows_clamp;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline handshakes.
   // ------------------------------------------------------------------------
   logic s1_valid_ff;
   logic s1_valid_in;
   logic s2_valid_ff;
   logic s2_valid_in;
   logic out_valid_ff;
   logic out_valid_in;
   logic s1_adv;
   logic s2_adv;
   logic out_load;
   logic req_fire;
   logic s1_emit_ff;
   logic s1_clear_ff;
   logic s1_done_ff;
   logic s2_emit_ff;
   logic s2_clear_ff;
   logic s2_done_ff;

   // A stage moves on when the one after it is free or moves too; an item
   // without a result leaves the second stage without using the output.
   assign s2_adv     = s2_valid_ff && (!s2_emit_ff || !out_valid_ff || rsp_tready);
   assign s1_adv     = s1_valid_ff && (!s2_valid_ff || s2_adv);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;
   assign out_load   = s2_adv && s2_emit_ff;

   always_comb begin
      s1_valid_in  = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_ff);
      out_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // ------------------------------------------------------------------------
   // Position tracking at the input beat.
   // ------------------------------------------------------------------------
   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic              restart;
   logic [ROW_W-1:0]  cur_row;
   logic [COL_W-1:0]  cur_col;
   logic [COLS_W-1:0] col_inc;
   logic [COLS_W-1:0] col_two;
   logic [ROWS_W-1:0] row_inc;
   logic              cur_emit;
   logic              cur_clear;
   logic              cur_done;

   // A frame start or a position outside the grid restarts at the corner.
   assign restart = req_tuser || ({1'b0, row_ff} >= rows_ff) ||
                    ({1'b0, col_ff} >= cols_ff);
   assign cur_row = restart ? '0 : row_ff;
   assign cur_col = restart ? '0 : col_ff;
   assign col_inc = {1'b0, cur_col} + COLS_W'(1);
   assign col_two = {1'b0, cur_col} + COLS_W'(2);
   assign row_inc = {1'b0, cur_row} + ROWS_W'(1);

   // Interior cell of the row above, its clear and its last-cell marks.
   assign cur_emit  = (cur_row >= ROW_W'(2)) && (cur_col != '0) && (col_inc < cols_ff);
   assign cur_clear = (cur_row == '0) && (cur_col == '0);
   assign cur_done  = (row_inc == rows_ff) && (col_two == cols_ff);

   // Raster advance with wrap at the end of a row and of the grid.
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (req_fire) begin
         if (col_inc >= cols_ff) begin
            col_in = '0;
            row_in = (row_inc >= rows_ff) ? '0 : row_inc[ROW_W-1:0];
         end else begin
            col_in = col_inc[COL_W-1:0];
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: line memory read returns, stencil sum.
   // ------------------------------------------------------------------------
   logic [HEAT_WIDTH-1:0] s1_heat_ff;
   logic [ROW_W-1:0]      s1_row_ff;
   logic [COL_W-1:0]      s1_col_ff;
   logic [HEAT_WIDTH-1:0] left_ff;
   logic [HEAT_WIDTH-1:0] left_in;
   logic [HEAT_WIDTH-1:0] up;
   logic [HEAT_WIDTH-1:0] centre;
   logic [HEAT_WIDTH-1:0] right;
   logic [SUM_W-1:0]      sum;
   logic [HEAT_WIDTH-1:0] avg;
   logic [HEAT_WIDTH-1:0] diff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_heat_ff  <= req_tdata[HEAT_WIDTH-1:0];
         s1_row_ff   <= cur_row - ROW_W'(1);
         s1_col_ff   <= cur_col;
         s1_emit_ff  <= cur_emit;
         s1_clear_ff <= cur_clear;
         s1_done_ff  <= cur_done;
      end
   end

   jhs_lines #(
      .DEPTH   (MAX_COLUMNS),
      .HEAT_W  (HEAT_WIDTH)
   ) u_lines (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_col  (cur_col),
      .wr_en   (s1_adv),
      .wr_col  (s1_col_ff),
      .wr_heat (s1_heat_ff),
      .up      (up),
      .centre  (centre),
      .right   (right)
   );

   // The left neighbor is the center value seen by the previous cell of the row.
   assign left_in = s1_adv ? centre : left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   // Average of the four neighbors, truncated, and the change it makes.
   assign sum  = SUM_W'(up) + SUM_W'(s1_heat_ff) + SUM_W'(left_ff) + SUM_W'(right);
   assign avg  = sum[SUM_W-1:2];
   assign diff = (avg >= centre) ? (avg - centre) : (centre - avg);

   // ------------------------------------------------------------------------
   // Stage 2: running maximum of the change.
   // ------------------------------------------------------------------------
   logic [ROW_W-1:0]      s2_row_ff;
   logic [COL_W-1:0]      s2_col_ff;
   logic [HEAT_WIDTH-1:0] s2_heat_ff;
   logic [HEAT_WIDTH-1:0] s2_diff_ff;
   logic [HEAT_WIDTH-1:0] resid_ff;
   logic [HEAT_WIDTH-1:0] resid_in;
   logic [HEAT_WIDTH-1:0] resid_base;
   logic [HEAT_WIDTH-1:0] resid_new;

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_row_ff   <= s1_row_ff;
         s2_col_ff   <= s1_col_ff;
         s2_heat_ff  <= avg;
         s2_diff_ff  <= diff;
         s2_emit_ff  <= s1_emit_ff;
         s2_clear_ff <= s1_clear_ff;
         s2_done_ff  <= s1_done_ff;
      end
   end

   // The sweep's first cell clears the maximum; interior cells raise it.
   assign resid_base = s2_clear_ff ? '0 : resid_ff;
   assign resid_new  = (s2_emit_ff && (s2_diff_ff > resid_base)) ? s2_diff_ff : resid_base;
   assign resid_in   = s2_adv ? resid_new : resid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         resid_ff <= '0;
      end else begin
         resid_ff <= resid_in;
      end
   end

   // ------------------------------------------------------------------------
   // Output register.
   // ------------------------------------------------------------------------
   logic [ROW_W-1:0]      out_row_ff;
   logic [COL_W-1:0]      out_col_ff;
   logic [HEAT_WIDTH-1:0] out_heat_ff;
   logic [HEAT_WIDTH-1:0] out_resid_ff;
   logic                  out_done_ff;

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_row_ff   <= s2_row_ff;
         out_col_ff   <= s2_col_ff;
         out_heat_ff  <= s2_heat_ff;
         out_resid_ff <= resid_new;
         out_done_ff  <= s2_done_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'({out_resid_ff, out_heat_ff, out_col_ff, out_row_ff});
   assign rsp_tlast  = out_done_ff;

`ifndef SYNTHESIS
   // Within a sweep the reported maximum never falls.
   assert property (@(posedge clock) disable iff (reset)
      (s2_adv && !s2_clear_ff) |=> (resid_ff >= $past(resid_ff)))
      else $error("running residual decreased within a sweep");

   // Result beats only ever carry interior columns.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_col_ff != '0) && (({1'b0, out_col_ff} + COLS_W'(1)) < cols_ff)))
      else $error("result beat for a border column");

   // The last-cell mark sits on the bottom right interior cell.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_done_ff) |->
         (({1'b0, out_row_ff} == rows_ff - ROWS_W'(2)) &&
          ({1'b0, out_col_ff} == cols_ff - COLS_W'(2))))
      else $error("sweep end marked on the wrong cell");

   // A stage holding an item never takes a new one without passing it on.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && req_fire) |-> s2_valid_in)
      else $error("stage 1 item overwritten");
`endif

endmodule : jacobi_heat_stencil_sweep
`default_nettype wire

FILE: design/jhs_lines.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Jacobi heat stencil line memories
// Holds the two previous grid rows in synchronous memories with registered
// reads. Returns the up, center and right neighbors of a column and forwards
// the write of the item ahead when it hits the column or the next column.
// ----------------------------------------------------------------------------
module jhs_lines
   import jhs_pkg::*;
#(
   parameter  int DEPTH  = MAX_COLUMNS_DEFAULT,
   parameter  int HEAT_W = HEAT_WIDTH_DEFAULT,
   localparam int COL_W  = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [COL_W-1:0]  rd_col,
   input  wire logic              wr_en,
   input  wire logic [COL_W-1:0]  wr_col,
   input  wire logic [HEAT_W-1:0] wr_heat,
   output logic      [HEAT_W-1:0] up,
   output logic      [HEAT_W-1:0] centre,
   output logic      [HEAT_W-1:0] right
);

   // Line storage: older holds row r-2, recent holds row r-1.
   logic [HEAT_W-1:0] older_mem  [DEPTH];
   logic [HEAT_W-1:0] recent_mem [DEPTH];

   logic [HEAT_W-1:0] older_q_ff;
   logic [HEAT_W-1:0] recent_c_q_ff;
   logic [HEAT_W-1:0] recent_n_q_ff;
   logic [HEAT_W-1:0] fwd_heat_ff;
   logic [HEAT_W-1:0] fwd_centre_ff;
   logic              hit_c_ff;
   logic              hit_c_in;
   logic              hit_n_ff;
   logic              hit_n_in;
   logic [COL_W-1:0]  rd_next;

   assign rd_next = rd_col + COL_W'(1);

   // A write in the same cycle as a read of that entry is forwarded.
   assign hit_c_in = wr_en && (wr_col == rd_col);
   assign hit_n_in = wr_en && (wr_col == rd_next);

   // The row moves down: recent becomes older, the new cell enters recent.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         older_mem[wr_col]  <= centre;
         recent_mem[wr_col] <= wr_heat;
      end
      if (rd_en) begin
         older_q_ff    <= older_mem[rd_col];
         recent_c_q_ff <= recent_mem[rd_col];
         recent_n_q_ff <= recent_mem[rd_next];
         fwd_heat_ff   <= wr_heat;
         fwd_centre_ff <= centre;
      end
   end

   // Forwarding flags, held with the read data.
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_c_ff <= 1'b0;
         hit_n_ff <= 1'b0;
      end else if (rd_en) begin
         hit_c_ff <= hit_c_in;
         hit_n_ff <= hit_n_in;
      end
   end

   // Neighbor values as seen after all earlier writes.
   assign up     = hit_c_ff ? fwd_centre_ff : older_q_ff;
   assign centre = hit_c_ff ? fwd_heat_ff   : recent_c_q_ff;
   assign right  = hit_n_ff ? fwd_heat_ff   : recent_n_q_ff;

endmodule : jhs_lines
`default_nettype wire
